[rtl/core/flc_pkg.sv]
// shared constants and types for the facility location cost evaluator
package flc_pkg;

    // request codes
    localparam logic [1:0] REQ_OPEN  = 2'd0;
    localparam logic [1:0] REQ_TRANS = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_MAXD = 2'd1;
    localparam logic [1:0] REG_PEN  = 2'd2;

    localparam int FIELD_W = 24;  // cost_value, max_distance, penalty_amount
    localparam int TOTAL_W = 31;
    localparam int COUNT_W = 6;
    localparam int ACC_W   = 40;  // accumulator width, wide enough for the default parameters

    // per-cycle control broadcast to every lane
    typedef struct packed {
        logic start;  // reset least cost to the no-facility sentinel
        logic upd;    // read data of an open column is on the ram output
    } lane_ctrl_t;

endpackage

[rtl/core/facility_location_cost_eval_core.sv]
// top level of the facility location cost evaluator
//
//  channel  direction  handshake         payload
//  s_       in         s_valid/s_ready   req_type, row_index, col_index, cost_value, genome
//  m_       out        m_valid/m_ready   total_cost, open_count, penalized_count
//  apb      in         psel/penable      constrained_mode, max_distance, penalty_amount
//
//  load items may follow each other back to back
//  an evaluate item runs a column scan over the row rams, then the merge stage
//  walking the lanes
//  s_ready is high only while no evaluation is running; a result waiting in the
//  output register does not stop loads or the next evaluation, only its final write
//  reset is synchronous active low and clears control and configuration; cost
//  tables are not cleared and must be loaded before use
module facility_location_cost_eval_core #(
    parameter int LOCATIONS = 32,
    parameter int COST_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [4:0]                    s_row_index,
    input  logic [4:0]                    s_col_index,
    input  logic [flc_pkg::FIELD_W-1:0]   s_cost_value,
    input  logic [31:0]                   s_genome,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [flc_pkg::TOTAL_W-1:0]   m_total_cost,
    output logic [flc_pkg::COUNT_W-1:0]   m_open_count,
    output logic [flc_pkg::COUNT_W-1:0]   m_penalized_count,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import flc_pkg::*;

    localparam int JW = $clog2(LOCATIONS);
    localparam int CW = $clog2(LOCATIONS+1);
    localparam logic [ACC_W-1:0] TOTAL_MAX = ACC_W'((64'd1 << TOTAL_W) - 64'd1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_MERGE  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic               mode_reg;
    logic [FIELD_W-1:0] maxd_reg;
    logic [FIELD_W-1:0] pen_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            maxd_reg <= {FIELD_W{1'b1}};
            pen_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MODE: mode_reg <= pwdata[0];
                REG_MAXD: maxd_reg <= pwdata[FIELD_W-1:0];
                REG_PEN:  pen_reg  <= pwdata[FIELD_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE: prdata = {31'd0, mode_reg};
            REG_MAXD: prdata = 32'(maxd_reg);
            REG_PEN:  prdata = 32'(pen_reg);
            default:  prdata = '0;
        endcase
    end

    // input decode
    logic                 s_acc;
    logic                 row_ok, col_ok;
    logic                 open_we, trans_we, eval_acc;
    logic [COST_BITS-1:0] wcost;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign row_ok   = int'(s_row_index) < LOCATIONS;
    assign col_ok   = int'(s_col_index) < LOCATIONS;
    assign open_we  = s_acc && (s_req_type == REQ_OPEN) && row_ok;
    assign trans_we = s_acc && (s_req_type == REQ_TRANS) && row_ok && col_ok;
    assign eval_acc = s_acc && (s_req_type == REQ_EVAL);
    assign wcost    = COST_BITS'(s_cost_value);

    // column scan control
    logic [JW-1:0]        j_reg, j_next;
    logic                 rd_vld_reg;
    logic [JW-1:0]        rd_idx_reg;
    logic [LOCATIONS-1:0] open_reg;
    logic [ACC_W-1:0]     sum_reg, sum_next;
    logic [CW-1:0]        ocnt_reg, ocnt_next;
    logic                 rd_en;
    logic                 col_open;
    logic [COST_BITS-1:0] open_rdata;
    logic                 merge_start_reg;
    logic                 merge_done;
    logic [ACC_W-1:0]     merge_total;
    logic [CW-1:0]        merge_pen;
    lane_ctrl_t           lane_ctrl;
    logic [COST_BITS:0]   least [LOCATIONS];

    assign rd_en    = (state_reg == ST_SCAN);
    assign col_open = rd_vld_reg && open_reg[rd_idx_reg];

    assign lane_ctrl.start = eval_acc;
    assign lane_ctrl.upd   = col_open;

    // opening cost table
    flc_ram #(
        .WIDTH(COST_BITS),
        .DEPTH(LOCATIONS)
    ) u_open_ram (
        .clk  (aclk),
        .we   (open_we),
        .waddr(JW'(s_row_index)),
        .wdata(wcost),
        .re   (rd_en),
        .raddr(j_reg),
        .rdata(open_rdata)
    );

    // one lane per customer row, all reading the same column each cycle
    for (genvar g = 0; g < LOCATIONS; g++) begin : g_lane
        flc_lane #(
            .LOCATIONS(LOCATIONS),
            .COST_BITS(COST_BITS)
        ) u_lane (
            .aclk (aclk),
            .ctrl (lane_ctrl),
            .we   (trans_we && (JW'(s_row_index) == JW'(g))),
            .waddr(JW'(s_col_index)),
            .wdata(wcost),
            .re   (rd_en),
            .raddr(j_reg),
            .least(least[g])
        );
    end

    flc_merge #(
        .LOCATIONS(LOCATIONS),
        .COST_BITS(COST_BITS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (merge_start_reg),
        .init_sum(sum_reg),
        .least   (least),
        .closed  (~open_reg),
        .mode    (mode_reg),
        .max_dist(maxd_reg),
        .pen_amt (pen_reg),
        .done    (merge_done),
        .total   (merge_total),
        .pen_cnt (merge_pen)
    );

    // opening cost sum follows the scan, adding each ram word in the cycle after its address
    always_comb begin
        sum_next  = sum_reg;
        ocnt_next = ocnt_reg;
        if (eval_acc) begin
            sum_next  = '0;
            ocnt_next = '0;
        end else if (col_open) begin
            sum_next  = sum_reg + ACC_W'(open_rdata);
            ocnt_next = ocnt_reg + CW'(1);
        end
    end

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] tot_reg;
    logic [CW-1:0]      ocnt_out_reg;
    logic [CW-1:0]      pcnt_out_reg;
    logic               out_load;
    logic [TOTAL_W-1:0] tot_sat;

    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign tot_sat  = (merge_total > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                : merge_total[TOTAL_W-1:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_IDLE: begin
                j_next = '0;
                if (eval_acc) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                j_next = j_reg + JW'(1);
                if (j_reg == JW'(LOCATIONS-1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (merge_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rd_vld_reg      <= 1'b0;
            merge_start_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rd_vld_reg      <= rd_en;
            merge_start_reg <= (state_reg == ST_DRAIN);
            m_valid_reg     <= m_valid_next;
        end
        j_reg      <= j_next;
        rd_idx_reg <= j_reg;
        sum_reg    <= sum_next;
        ocnt_reg   <= ocnt_next;
        if (eval_acc) begin
            open_reg <= LOCATIONS'(s_genome);
        end
        if (out_load) begin
            tot_reg      <= tot_sat;
            ocnt_out_reg <= ocnt_reg;
            pcnt_out_reg <= merge_pen;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_total_cost      = tot_reg;
    assign m_open_count      = COUNT_W'(ocnt_out_reg);
    assign m_penalized_count = COUNT_W'(pcnt_out_reg);

    // an accepted evaluation starts the scan at column zero
    a_eval_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_acc |=> (state_reg == ST_SCAN) && (j_reg == '0))
        else $error("evaluation did not start scanning");

    // the merge finishes only while the sequencer waits for it
    a_merge_done: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_done |-> (state_reg == ST_MERGE))
        else $error("merge done outside merge phase");

    // a new result only comes from the finish state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside finish state");

    // ram read data is never consumed outside the scan window
    a_scan_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        else $error("scan data outside scan window");

    // open count never exceeds the number of locations
    a_open_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (int'(ocnt_reg) <= LOCATIONS))
        else $error("open count out of range");
endmodule

[rtl/core/flc_ram.sv]
// generic single write, single registered read ram
module flc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/core/flc_lane.sv]
// one customer row: its transport costs and a running minimum over open columns
module flc_lane #(
    parameter int LOCATIONS = 32,
    parameter int COST_BITS = 24
) (
    input  logic                         aclk,
    input  flc_pkg::lane_ctrl_t          ctrl,
    input  logic                         we,
    input  logic [$clog2(LOCATIONS)-1:0] waddr,
    input  logic [COST_BITS-1:0]         wdata,
    input  logic                         re,
    input  logic [$clog2(LOCATIONS)-1:0] raddr,
    output logic [COST_BITS:0]           least
);
    import flc_pkg::*;

    logic [COST_BITS-1:0] rdata;
    logic [COST_BITS:0]   least_reg;
    logic [COST_BITS:0]   least_next;

    flc_ram #(
        .WIDTH(COST_BITS),
        .DEPTH(LOCATIONS)
    ) u_row_ram (
        .clk  (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        least_next = least_reg;
        if (ctrl.start) begin
            least_next = {1'b1, {COST_BITS{1'b0}}};
        end else if (ctrl.upd && ({1'b0, rdata} < least_reg)) begin
            least_next = {1'b0, rdata};
        end
    end

    always_ff @(posedge aclk) begin
        least_reg <= least_next;
    end

    assign least = least_reg;
endmodule

[rtl/core/flc_merge.sv]
// walks the lanes one per cycle, adding least costs of closed lanes and penalties
module flc_merge #(
    parameter int LOCATIONS = 32,
    parameter int COST_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [flc_pkg::ACC_W-1:0]           init_sum,
    input  logic [COST_BITS:0]                  least [LOCATIONS],
    input  logic [LOCATIONS-1:0]                closed,
    input  logic                                mode,
    input  logic [flc_pkg::FIELD_W-1:0]         max_dist,
    input  logic [flc_pkg::FIELD_W-1:0]         pen_amt,
    output logic                                done,
    output logic [flc_pkg::ACC_W-1:0]           total,
    output logic [$clog2(LOCATIONS+1)-1:0]      pen_cnt
);
    import flc_pkg::*;

    localparam int KW = $clog2(LOCATIONS);
    localparam int CW = $clog2(LOCATIONS+1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0] least_ext;
    logic            far;

    assign least_ext = ACC_W'(least[k_reg]);
    assign far = closed[k_reg] && mode && (least_ext > ACC_W'(max_dist));

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            k_next    = '0;
            acc_next  = init_sum;
            cnt_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + (closed[k_reg] ? least_ext : '0)
                     + (far ? ACC_W'(pen_amt) : '0);
            if (far) begin
                cnt_next = cnt_reg + CW'(1);
            end
            k_next = k_reg + KW'(1);
            if (k_reg == KW'(LOCATIONS-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        k_reg   <= k_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign done    = done_reg;
    assign total   = acc_reg;
    assign pen_cnt = cnt_reg;
endmodule
